// ===== design/otps_pkg.sv =====
// ----------------------------------------------------------------------------
// otps_pkg
// Shared codes, masks and the scratchpad CRC step of the polling sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package otps_pkg;

  // Bus command codes
  typedef logic [2:0] bus_cmd_t;
  localparam bus_cmd_t CMD_NONE      = 3'd0;
  localparam bus_cmd_t CMD_RESET     = 3'd1;
  localparam bus_cmd_t CMD_SKIP_ROM  = 3'd2;
  localparam bus_cmd_t CMD_CONVERT   = 3'd3;
  localparam bus_cmd_t CMD_MATCH_ROM = 3'd4;
  localparam bus_cmd_t CMD_READ_SP   = 3'd5;
  localparam bus_cmd_t CMD_READ_BYTE = 3'd6;

  // Configuration register indexes
  typedef logic [3:0] cfg_idx_t;
  localparam cfg_idx_t REG_CONV_TICKS  = 4'd0;
  localparam cfg_idx_t REG_INTVL_TICKS = 4'd1;
  localparam cfg_idx_t REG_DEV_COUNT   = 4'd2;
  localparam cfg_idx_t REG_DEV_KINDS   = 4'd3;

  // Sensor kinds and their magnitude masks
  typedef logic [1:0] dev_kind_t;
  localparam dev_kind_t KIND_WIDE   = 2'd0;
  localparam dev_kind_t KIND_NARROW = 2'd1;
  localparam logic [15:0] MASK_WIDE   = 16'h07FF;
  localparam logic [15:0] MASK_NARROW = 16'h00FF;
  localparam logic [15:0] SIGN_BIT    = 16'h8000;

  // Dallas CRC-8, reflected poly 0x8C, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/otps_temp_conv.sv =====
// ----------------------------------------------------------------------------
// otps_temp_conv
// Masks the raw scratchpad word by sensor kind and applies the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module otps_temp_conv
  import otps_pkg::*;
(
  input  wire logic [15:0]        raw_word,
  input  wire dev_kind_t          kind,
  output logic signed [11:0]      temperature
);

  logic [15:0] mask;
  logic [11:0] mag;

  // Kind decode
  always_comb begin
    unique case (kind)
      KIND_WIDE:   mask = MASK_WIDE;
      KIND_NARROW: mask = MASK_NARROW;
      default:     mask = '0;
    endcase
  end

  // Magnitude is at most 11 bits; negate in 12 bits when the sign bit is set
  assign mag = 12'(raw_word & mask);
  assign temperature = ((raw_word & SIGN_BIT) != '0) ? $signed(12'd0 - mag) : $signed(mag);

endmodule

`default_nettype wire

// ===== design/onewire_temp_poll_sequencer.sv =====
// ----------------------------------------------------------------------------
// onewire_temp_poll_sequencer
// 1-Wire temperature polling sequencer, one scheduler tick per request.
// ----------------------------------------------------------------------------
// Each input request is one scheduler tick and yields exactly one result: the
// bus command for that tick plus, at the end of a scratchpad read, the CRC
// status and the converted temperature. The sequencer state is updated at
// acceptance and the result is held in an output register, so a new tick is
// taken every clock while the result side keeps up; in_ready drops only while
// a held result is not taken. A round is reset, skip ROM, convert T,
// conversion wait, then per sensor reset, skip/match ROM, read scratchpad and
// SCRATCH_BYTES byte reads, then the interval wait. A write to any of the four
// known configuration registers reloads both tick counters.
`default_nettype none

module onewire_temp_poll_sequencer
  import otps_pkg::*;
#(
  parameter int MAX_DEVICES   = 8,
  parameter int SCRATCH_BYTES = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // tick requests
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_bus_byte,
  // results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_bus_command,
  output logic [2:0]             out_device_index,
  output logic                   out_result_valid,
  output logic                   out_crc_ok,
  output logic signed [11:0]     out_temperature,
  output logic                   out_round_done,
  // configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [3:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  localparam logic [2:0] PH_WAIT_NEXT  = 3'd0;
  localparam logic [2:0] PH_INIT       = 3'd1;
  localparam logic [2:0] PH_SKIP_ROM   = 3'd2;
  localparam logic [2:0] PH_START_CONV = 3'd3;
  localparam logic [2:0] PH_WAIT       = 3'd4;
  localparam logic [2:0] PH_MATCH_ROM  = 3'd5;
  localparam logic [2:0] PH_READ_REQ   = 3'd6;
  localparam logic [2:0] PH_READ_MEM   = 3'd7;

  localparam logic [3:0] LAST_BYTE = 4'(SCRATCH_BYTES - 1);
  localparam logic [3:0] MAX_DEV   = 4'(MAX_DEVICES);

  // Configuration registers
  logic [15:0] conv_ticks_r, intvl_ticks_r, dev_kinds_r;
  logic [3:0]  dev_count_r;

  // Sequencer state
  logic [2:0]  phase_r, phase_nxt;
  logic        read_pending_r, read_pending_nxt;
  logic [2:0]  cur_dev_r, cur_dev_nxt;
  logic [3:0]  byte_idx_r, byte_idx_nxt;
  logic [15:0] delay_cnt_r, delay_cnt_nxt;
  logic [15:0] intvl_cnt_r, intvl_cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;

  // Result register
  logic              out_valid_r;
  bus_cmd_t          cmd_r, cmd_nxt;
  logic [2:0]        dev_idx_r;
  logic              res_valid_r, res_valid_nxt;
  logic              crc_ok_r, crc_ok_nxt;
  logic signed [11:0] temp_r, temp_nxt;
  logic              done_r, done_nxt;

  logic              in_acc, cfg_acc;
  logic [3:0]        amount;
  dev_kind_t         kind;
  logic signed [11:0] conv_temp;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign amount = (dev_count_r > MAX_DEV) ? MAX_DEV : dev_count_r;
  assign kind   = dev_kind_t'(dev_kinds_r >> {cur_dev_r, 1'b0});

  otps_temp_conv u_conv (
    .raw_word    (temp_word_nxt),
    .kind        (kind),
    .temperature (conv_temp)
  );

  // Next-state and result logic for one tick
  always_comb begin
    phase_nxt        = phase_r;
    read_pending_nxt = read_pending_r;
    cur_dev_nxt      = cur_dev_r;
    byte_idx_nxt     = byte_idx_r;
    delay_cnt_nxt    = delay_cnt_r;
    intvl_cnt_nxt    = intvl_cnt_r;
    crc_nxt          = crc_r;
    temp_word_nxt    = temp_word_r;
    cmd_nxt          = CMD_NONE;
    res_valid_nxt    = 1'b0;
    crc_ok_nxt       = 1'b0;
    temp_nxt         = '0;
    done_nxt         = 1'b0;
    unique case (phase_r)
      PH_INIT: begin
        cmd_nxt   = CMD_RESET;
        phase_nxt = PH_SKIP_ROM;
      end
      PH_SKIP_ROM: begin
        if (!read_pending_r) begin
          cmd_nxt   = CMD_SKIP_ROM;
          phase_nxt = PH_START_CONV;
        end else if (amount == 4'd1) begin
          cmd_nxt   = CMD_SKIP_ROM;
          phase_nxt = PH_READ_REQ;
        end else if (amount > 4'd1) begin
          phase_nxt = PH_MATCH_ROM;
        end
      end
      PH_START_CONV: begin
        cmd_nxt   = CMD_CONVERT;
        phase_nxt = PH_WAIT;
      end
      PH_WAIT: begin
        delay_cnt_nxt = delay_cnt_r - 16'd1;
        if (delay_cnt_nxt == '0) begin
          delay_cnt_nxt    = conv_ticks_r;
          read_pending_nxt = 1'b1;
          phase_nxt        = PH_INIT;
        end
      end
      PH_MATCH_ROM: begin
        cmd_nxt   = CMD_MATCH_ROM;
        phase_nxt = PH_READ_REQ;
      end
      PH_READ_REQ: begin
        cmd_nxt          = CMD_READ_SP;
        byte_idx_nxt     = '0;
        crc_nxt          = '0;
        read_pending_nxt = 1'b0;
        phase_nxt        = PH_READ_MEM;
      end
      PH_READ_MEM: begin
        cmd_nxt = CMD_READ_BYTE;
        crc_nxt = crc8_update(crc_r, in_bus_byte);
        if (byte_idx_r == 4'd0) begin
          temp_word_nxt = {temp_word_r[15:8], in_bus_byte};
        end else if (byte_idx_r == 4'd1) begin
          temp_word_nxt = {in_bus_byte, temp_word_r[7:0]};
        end
        if (byte_idx_r >= LAST_BYTE) begin
          byte_idx_nxt  = '0;
          delay_cnt_nxt = conv_ticks_r;
          res_valid_nxt = 1'b1;
          crc_ok_nxt    = (crc_nxt == '0);
          temp_nxt      = crc_ok_nxt ? conv_temp : '0;
          if ({1'b0, cur_dev_r} + 4'd1 >= amount) begin
            done_nxt    = 1'b1;
            cur_dev_nxt = '0;
            phase_nxt   = PH_WAIT_NEXT;
          end else begin
            cur_dev_nxt      = cur_dev_r + 3'd1;
            read_pending_nxt = 1'b1;
            phase_nxt        = PH_INIT;
          end
        end else begin
          byte_idx_nxt = byte_idx_r + 4'd1;
        end
      end
      default: begin
        intvl_cnt_nxt = intvl_cnt_r - 16'd1;
        if (intvl_cnt_nxt == '0) begin
          intvl_cnt_nxt = intvl_ticks_r;
          phase_nxt     = PH_INIT;
        end
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_ticks_r  <= 16'd75;
      intvl_ticks_r <= 16'd100;
      dev_count_r   <= 4'd1;
      dev_kinds_r   <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_CONV_TICKS:  conv_ticks_r  <= cfg_data;
        REG_INTVL_TICKS: intvl_ticks_r <= cfg_data;
        REG_DEV_COUNT:   dev_count_r   <= cfg_data[3:0];
        REG_DEV_KINDS:   dev_kinds_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state; a known config write reloads both counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT_NEXT;
      read_pending_r <= 1'b0;
      cur_dev_r      <= '0;
      byte_idx_r     <= '0;
      delay_cnt_r    <= 16'd75;
      intvl_cnt_r    <= 16'd100;
      crc_r          <= '0;
      temp_word_r    <= '0;
    end else begin
      if (in_acc) begin
        phase_r        <= phase_nxt;
        read_pending_r <= read_pending_nxt;
        cur_dev_r      <= cur_dev_nxt;
        byte_idx_r     <= byte_idx_nxt;
        delay_cnt_r    <= delay_cnt_nxt;
        intvl_cnt_r    <= intvl_cnt_nxt;
        crc_r          <= crc_nxt;
        temp_word_r    <= temp_word_nxt;
      end
      if (cfg_acc) begin
        unique case (cfg_index) inside
          REG_CONV_TICKS: begin
            delay_cnt_r <= cfg_data;
            intvl_cnt_r <= intvl_ticks_r;
          end
          REG_INTVL_TICKS: begin
            delay_cnt_r <= conv_ticks_r;
            intvl_cnt_r <= cfg_data;
          end
          REG_DEV_COUNT, REG_DEV_KINDS: begin
            delay_cnt_r <= conv_ticks_r;
            intvl_cnt_r <= intvl_ticks_r;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r       <= cmd_nxt;
      dev_idx_r   <= cur_dev_r;
      res_valid_r <= res_valid_nxt;
      crc_ok_r    <= crc_ok_nxt;
      temp_r      <= temp_nxt;
      done_r      <= done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bus_command  = cmd_r;
  assign out_device_index = dev_idx_r;
  assign out_result_valid = res_valid_r;
  assign out_crc_ok       = crc_ok_r;
  assign out_temperature  = temp_r;
  assign out_round_done   = done_r;

  // Checks
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAIT_NEXT |-> !read_pending_r)
    else $error("read pending while waiting for next round");

  a_byte_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_READ_MEM |-> byte_idx_r <= LAST_BYTE)
    else $error("scratchpad byte index past last byte");

  a_dev_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_dev_r} < MAX_DEV)
    else $error("current device beyond device limit");

  a_bad_crc_no_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !crc_ok_r |-> temp_r == '0)
    else $error("temperature reported without good CRC");

  a_status_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (crc_ok_r || done_r) |-> res_valid_r && cmd_r == CMD_READ_BYTE)
    else $error("read status outside a completed scratchpad read");

endmodule

`default_nettype wire

// ===== verif/onewire_temp_poll_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// onewire_temp_poll_sequencer_tb
// Self-checking bench for the 1-Wire temperature polling sequencer.
// ----------------------------------------------------------------------------
// Tick requests go in on the in_ channel, with bursts and gaps. Results are
// taken on the out_ channel while the receiver stalls on its own schedule.
// A cycle-free model of the sequencer runs on every accepted request and
// queues the result it expects. Scratchpad bytes are served from frames with
// a valid CRC, or with one flipped bit, so that reads report real readings.
// Directed tests cover the default timing, temperature corners, sensor kinds,
// device count limits, count changes in mid-round, ignored register indexes,
// receiver hold-off and counter wrap. Random phases with random settings
// follow.
module onewire_temp_poll_sequencer_tb
  import otps_pkg::*;
();

  localparam int MAX_SENSORS = 8;
  localparam int SP_BYTES    = 9;

  // Sequencer phases, as tracked by the model
  typedef enum logic [2:0] {
    SEQ_IDLE_WAIT, SEQ_RESET, SEQ_ADDR, SEQ_CONVERT,
    SEQ_CONV_WAIT, SEQ_MATCH, SEQ_READ_CMD, SEQ_READ_BYTES
  } seq_phase_t;

  typedef struct packed {
    bus_cmd_t    cmd;
    logic [2:0]  dev;
    logic        rv;
    logic        ok;
    logic [11:0] temp;
    logic        done;
  } tick_result_t;

  typedef struct packed {
    logic [15:0] word;
    logic        bad;
  } frame_plan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_bus_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_bus_command;
  logic [2:0]  out_device_index;
  logic        out_result_valid;
  logic        out_crc_ok;
  logic signed [11:0] out_temperature;
  logic        out_round_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = REG_CONV_TICKS;
  logic [15:0] cfg_data = 16'd0;

  // Model copy of the registers
  logic [15:0] r_conv;
  logic [15:0] r_intvl;
  logic [3:0]  r_count;
  logic [15:0] r_kinds;

  // Model copy of the sequencer state
  seq_phase_t  m_phase;
  logic        m_pending;
  logic [2:0]  m_dev;
  logic [3:0]  m_byte_idx;
  logic [15:0] m_delay;
  logic [15:0] m_interval;
  logic [7:0]  m_crc;
  logic [15:0] m_word;

  tick_result_t expected_ticks[$];
  frame_plan_t  planned_frames[$];
  logic [7:0]   sp_frame [SP_BYTES];
  tick_result_t want;

  int error_count = 0;
  int rounds_done = 0;
  int ticks_sent  = 0;
  int burst_left  = 0;
  int gap_max     = 0;
  int stall_pct   = 0;
  int stall_left  = 0;
  int hold_cycles = 0;

  onewire_temp_poll_sequencer #(
    .MAX_DEVICES   (MAX_SENSORS),
    .SCRATCH_BYTES (SP_BYTES)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_bus_byte      (in_bus_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bus_command  (out_bus_command),
    .out_device_index (out_device_index),
    .out_result_valid (out_result_valid),
    .out_crc_ok       (out_crc_ok),
    .out_temperature  (out_temperature),
    .out_round_done   (out_round_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 50 MHz-style clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (error_count < 100) $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Dallas CRC-8, fed LSB first
  function automatic logic [7:0] dallas_crc_byte(input logic [7:0] crc,
                                                 input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c = {1'b0, c[7:1]};
      if (fb) c = c ^ 8'h8C;
    end
    return c;
  endfunction

  // Next scratchpad image: planned word or random, CRC closed, maybe damaged
  task automatic load_scratchpad();
    frame_plan_t p;
    logic [7:0]  c;
    int          i;
    int          k;
    int          b;
    if (planned_frames.size() != 0) begin
      p = planned_frames.pop_front();
    end else begin
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(9))
          0: p.word = 16'h0000;
          1: p.word = 16'h07FF;
          2: p.word = 16'h0800;
          3: p.word = 16'h8000;
          4: p.word = 16'hFFFF;
          5: p.word = 16'h00FF;
          6: p.word = 16'h0100;
          7: p.word = 16'h80FF;
          8: p.word = 16'hFF00;
          default: p.word = 16'h7FFF;
        endcase
      end else begin
        p.word = 16'($urandom);
      end
      p.bad = ($urandom_range(99) < 12);
    end
    sp_frame[0] = p.word[7:0];
    sp_frame[1] = p.word[15:8];
    for (i = 2; i < SP_BYTES - 1; i++) sp_frame[i] = 8'($urandom);
    c = 8'd0;
    for (i = 0; i < SP_BYTES - 1; i++) c = dallas_crc_byte(c, sp_frame[i]);
    sp_frame[SP_BYTES - 1] = c;
    if (p.bad) begin
      k = $urandom_range(SP_BYTES - 1);
      b = $urandom_range(7);
      sp_frame[k][b] = ~sp_frame[k][b];
    end
  endtask

  // Advance the model by one tick and queue the result it yields
  task automatic predict_tick(input logic [7:0] data);
    tick_result_t r;
    int           amount;
    logic [15:0]  mask;
    logic [15:0]  mag;
    logic [15:0]  neg;
    amount = (r_count > MAX_SENSORS) ? MAX_SENSORS : int'(r_count);
    r.cmd  = CMD_NONE;
    r.dev  = m_dev;
    r.rv   = 1'b0;
    r.ok   = 1'b0;
    r.temp = 12'd0;
    r.done = 1'b0;
    case (m_phase)
      SEQ_RESET: begin
        r.cmd = CMD_RESET;
        m_phase = SEQ_ADDR;
      end
      SEQ_ADDR: begin
        if (!m_pending) begin
          r.cmd = CMD_SKIP_ROM;
          m_phase = SEQ_CONVERT;
        end else if (amount == 1) begin
          r.cmd = CMD_SKIP_ROM;
          m_phase = SEQ_READ_CMD;
        end else if (amount > 1) begin
          m_phase = SEQ_MATCH;
        end
      end
      SEQ_CONVERT: begin
        r.cmd = CMD_CONVERT;
        m_phase = SEQ_CONV_WAIT;
      end
      SEQ_CONV_WAIT: begin
        m_delay = m_delay - 16'd1;
        if (m_delay == 16'd0) begin
          m_delay = r_conv;
          m_pending = 1'b1;
          m_phase = SEQ_RESET;
        end
      end
      SEQ_MATCH: begin
        r.cmd = CMD_MATCH_ROM;
        m_phase = SEQ_READ_CMD;
      end
      SEQ_READ_CMD: begin
        r.cmd = CMD_READ_SP;
        m_byte_idx = 4'd0;
        m_crc = 8'd0;
        m_pending = 1'b0;
        m_phase = SEQ_READ_BYTES;
        load_scratchpad();
      end
      SEQ_READ_BYTES: begin
        r.cmd = CMD_READ_BYTE;
        m_crc = dallas_crc_byte(m_crc, data);
        if (m_byte_idx == 4'd0) m_word[7:0] = data;
        else if (m_byte_idx == 4'd1) m_word[15:8] = data;
        if (m_byte_idx >= SP_BYTES - 1) begin
          m_byte_idx = 4'd0;
          m_delay = r_conv;
          r.rv = 1'b1;
          r.ok = (m_crc == 8'd0);
          if (r.ok) begin
            case (dev_kind_t'(r_kinds[int'(r.dev) * 2 +: 2]))
              KIND_WIDE:   mask = MASK_WIDE;
              KIND_NARROW: mask = MASK_NARROW;
              default:     mask = 16'd0;
            endcase
            mag = m_word & mask;
            neg = 16'h1000 - mag;
            r.temp = ((m_word & SIGN_BIT) != 16'd0) ? neg[11:0] : mag[11:0];
          end
          if (int'(m_dev) + 1 >= amount) begin
            r.done = 1'b1;
            m_dev = 3'd0;
            m_phase = SEQ_IDLE_WAIT;
            rounds_done++;
          end else begin
            m_dev = m_dev + 3'd1;
            m_pending = 1'b1;
            m_phase = SEQ_RESET;
          end
        end else begin
          m_byte_idx = m_byte_idx + 4'd1;
        end
      end
      default: begin
        m_interval = m_interval - 16'd1;
        if (m_interval == 16'd0) begin
          m_interval = r_intvl;
          m_phase = SEQ_RESET;
        end
      end
    endcase
    expected_ticks.push_back(r);
  endtask

  // One tick request; bus byte follows the scratchpad while reading
  task automatic send_tick();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        @(negedge clk) in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_bus_byte = (m_phase == SEQ_READ_BYTES) ? sp_frame[m_byte_idx] : 8'($urandom);
    do @(posedge clk); while (!in_ready);
    predict_tick(in_bus_byte);
    ticks_sent++;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick();
  endtask

  task automatic run_rounds(input int k);
    int target;
    target = rounds_done + k;
    while (rounds_done < target) send_tick();
  endtask

  task automatic run_until_device(input logic [2:0] d);
    while (!(m_phase == SEQ_READ_BYTES && m_dev == d)) send_tick();
  endtask

  // Stop offering and wait for every queued result
  task automatic drain_results();
    @(negedge clk) in_valid = 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  // Register write; any known index reloads both tick counters
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CONV_TICKS:  r_conv  = data;
      REG_INTVL_TICKS: r_intvl = data;
      REG_DEV_COUNT:   r_count = data[3:0];
      REG_DEV_KINDS:   r_kinds = data;
      default: ;
    endcase
    if (idx <= REG_DEV_KINDS) begin
      m_delay    = r_conv;
      m_interval = r_intvl;
    end
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic plan_frame(input logic [15:0] word, input logic bad);
    frame_plan_t p;
    p.word = word;
    p.bad  = bad;
    planned_frames.push_back(p);
  endtask

  // Receiver: long hold-off when asked, otherwise short random stalls
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left = stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready = 1'b1;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        flag_error($sformatf("result with nothing expected, cmd %0d", out_bus_command));
      end else begin
        want = expected_ticks.pop_front();
        if (out_bus_command !== want.cmd)
          flag_error($sformatf("bus_command %0d, want %0d", out_bus_command, want.cmd));
        if (out_device_index !== want.dev)
          flag_error($sformatf("device_index %0d, want %0d", out_device_index, want.dev));
        if (out_result_valid !== want.rv)
          flag_error($sformatf("result_valid %0b, want %0b", out_result_valid, want.rv));
        if (out_crc_ok !== want.ok)
          flag_error($sformatf("crc_ok %0b, want %0b", out_crc_ok, want.ok));
        if (out_temperature !== want.temp)
          flag_error($sformatf("temperature %0d, want %0d", out_temperature,
                               $signed(want.temp)));
        if (out_round_done !== want.done)
          flag_error($sformatf("round_done %0b, want %0b", out_round_done, want.done));
      end
    end
  end

  // Default timing: one full round with the reset values
  task automatic test_reset_defaults();
    gap_max = 3;
    stall_pct = 20;
    plan_frame(16'h0191, 1'b0);
    run_rounds(1);
    drain_results();
  endtask

  // Single sensor, short waits, reading corners and damaged frames
  task automatic test_temperature_corners();
    gap_max = 0;
    stall_pct = 0;
    write_reg(REG_CONV_TICKS, 16'd1);
    write_reg(REG_INTVL_TICKS, 16'd1);
    write_reg(REG_DEV_COUNT, 16'd1);
    write_reg(REG_DEV_KINDS, 16'h0000);
    plan_frame(16'h0000, 1'b0);
    plan_frame(16'h07FF, 1'b0);
    plan_frame(16'hFFFF, 1'b0);
    plan_frame(16'h8000, 1'b0);
    plan_frame(16'h0800, 1'b0);
    plan_frame(16'hF801, 1'b0);
    plan_frame(16'h0550, 1'b1);
    plan_frame(16'hFFFF, 1'b1);
    run_rounds(8);
    drain_results();
  endtask

  // All four kinds across eight sensors, then all-narrow and all-masked
  task automatic test_sensor_kinds();
    gap_max = 2;
    stall_pct = 30;
    write_reg(REG_DEV_COUNT, 16'd8);
    write_reg(REG_DEV_KINDS, 16'hE4E4);
    repeat (8) plan_frame(16'hFFFF, 1'b0);
    run_rounds(1);
    drain_results();
    write_reg(REG_DEV_KINDS, 16'h5555);
    repeat (4) plan_frame(16'h80FF, 1'b0);
    repeat (4) plan_frame(16'h00FF, 1'b0);
    run_rounds(1);
    drain_results();
    write_reg(REG_DEV_KINDS, 16'hFFFF);
    run_rounds(1);
    drain_results();
  endtask

  // No sensors parks the addressing step; too many is capped at eight
  task automatic test_device_count_limits();
    gap_max = 1;
    stall_pct = 10;
    write_reg(REG_CONV_TICKS, 16'd2);
    write_reg(REG_DEV_COUNT, 16'd0);
    run_ticks(40);
    drain_results();
    write_reg(REG_DEV_COUNT, 16'd3);
    run_rounds(1);
    drain_results();
    write_reg(REG_DEV_COUNT, 16'd15);
    write_reg(REG_DEV_KINDS, 16'h0000);
    run_rounds(1);
    drain_results();
  endtask

  // Count lowered below the current sensor, then raised, in mid-round
  task automatic test_count_change_mid_round();
    gap_max = 4;
    stall_pct = 40;
    write_reg(REG_DEV_COUNT, 16'd6);
    run_until_device(3'd3);
    drain_results();
    write_reg(REG_DEV_COUNT, 16'd2);
    run_rounds(1);
    drain_results();
    run_until_device(3'd1);
    drain_results();
    write_reg(REG_DEV_COUNT, 16'd5);
    run_rounds(1);
    drain_results();
  endtask

  // Unused indexes change nothing; a real write reloads the running wait
  task automatic test_config_ignored_index();
    int idx;
    gap_max = 0;
    stall_pct = 0;
    write_reg(REG_DEV_COUNT, 16'd1);
    write_reg(REG_INTVL_TICKS, 16'd2);
    write_reg(REG_CONV_TICKS, 16'd40);
    run_ticks(20);
    drain_results();
    for (idx = REG_DEV_KINDS + 1; idx < 16; idx++) write_reg(cfg_idx_t'(idx), 16'($urandom));
    run_ticks(5);
    drain_results();
    write_reg(REG_CONV_TICKS, 16'd5);
    run_rounds(1);
    drain_results();
  endtask

  // Receiver holds off while requests keep coming, then a full drain
  task automatic test_receiver_hold();
    gap_max = 0;
    stall_pct = 0;
    write_reg(REG_CONV_TICKS, 16'd3);
    write_reg(REG_DEV_COUNT, 16'd2);
    hold_cycles = 300;
    run_ticks(60);
    drain_results();
  endtask

  // Zero loads wrap instead of ending the wait; the largest loads keep it
  // running; a fresh load then finishes a round
  task automatic test_counter_wrap();
    gap_max = 0;
    stall_pct = 0;
    write_reg(REG_DEV_COUNT, 16'd1);
    run_rounds(1);
    drain_results();
    // interval wait
    write_reg(REG_INTVL_TICKS, 16'd0);
    run_ticks(30);
    drain_results();
    write_reg(REG_INTVL_TICKS, 16'hFFFF);
    run_ticks(10);
    drain_results();
    // conversion wait
    write_reg(REG_INTVL_TICKS, 16'd2);
    write_reg(REG_CONV_TICKS, 16'd4);
    while (m_phase != SEQ_CONV_WAIT) send_tick();
    drain_results();
    write_reg(REG_CONV_TICKS, 16'd0);
    run_ticks(30);
    drain_results();
    write_reg(REG_CONV_TICKS, 16'hFFFF);
    run_ticks(10);
    drain_results();
    write_reg(REG_CONV_TICKS, 16'd3);
    run_rounds(1);
    drain_results();
  endtask

  // Random settings per phase, random idling per phase
  task automatic test_random_rounds();
    int start;
    int pick;
    start = ticks_sent;
    while (ticks_sent - start < 300) begin
      drain_results();
      pick = $urandom_range(99);
      if (pick < 70) write_reg(REG_CONV_TICKS, 16'($urandom_range(1, 6)));
      else if (pick < 90) write_reg(REG_CONV_TICKS, 16'($urandom_range(7, 60)));
      else write_reg(REG_CONV_TICKS, 16'($urandom_range(61, 400)));
      pick = $urandom_range(99);
      if (pick < 75) write_reg(REG_INTVL_TICKS, 16'($urandom_range(1, 6)));
      else write_reg(REG_INTVL_TICKS, 16'($urandom_range(7, 120)));
      pick = $urandom_range(99);
      if (pick < 8) write_reg(REG_DEV_COUNT, 16'd0);
      else if (pick < 18) write_reg(REG_DEV_COUNT, 16'($urandom_range(9, 15)));
      else if (pick < 50) write_reg(REG_DEV_COUNT, 16'd1);
      else write_reg(REG_DEV_COUNT, 16'($urandom_range(2, 8)));
      if ($urandom_range(3) != 0) write_reg(REG_DEV_KINDS, 16'($urandom));
      if ($urandom_range(9) == 0)
        write_reg(cfg_idx_t'($urandom_range(REG_DEV_KINDS + 1, 15)), 16'($urandom));
      case ($urandom_range(2))
        0: begin gap_max = 0; stall_pct = 0; end
        1: begin gap_max = 2; stall_pct = 20; end
        default: begin gap_max = 6; stall_pct = 50; end
      endcase
      run_ticks($urandom_range(40, 150));
    end
    drain_results();
  endtask

  initial begin
    r_conv     = 16'd75;
    r_intvl    = 16'd100;
    r_count    = 4'd1;
    r_kinds    = 16'd0;
    m_phase    = SEQ_IDLE_WAIT;
    m_pending  = 1'b0;
    m_dev      = 3'd0;
    m_byte_idx = 4'd0;
    m_delay    = 16'd75;
    m_interval = 16'd100;
    m_crc      = 8'd0;
    m_word     = 16'd0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    test_reset_defaults();
    test_temperature_corners();
    test_sensor_kinds();
    test_device_count_limits();
    test_count_change_mid_round();
    test_config_ignored_index();
    test_receiver_hold();
    test_counter_wrap();
    test_random_rounds();

    // settle: any stray result would show up here
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("onewire_temp_poll_sequencer_tb: done, clean");
    end else begin
      $display("onewire_temp_poll_sequencer_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("onewire_temp_poll_sequencer_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/otps_pkg.sv
design/otps_temp_conv.sv
design/onewire_temp_poll_sequencer.sv
verif/onewire_temp_poll_sequencer_tb.sv
